// ===== hdl/ring_time_interp_search_defines.svh =====
// Assertion macros used by the bound checker file.
`ifndef RING_TIME_INTERP_SEARCH_DEFINES_SVH
`define RING_TIME_INTERP_SEARCH_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define RTIS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs across reset.
`define RTIS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/rtis_pkg.sv =====
package rtis_pkg;

    localparam int DEF_DEPTH       = 64;
    localparam int DEF_TIME_WIDTH  = 32;
    localparam int DEF_WEIGHT_FRAC = 16;

    // result classification
    localparam logic [1:0] CASE_EXACT  = 2'd0;
    localparam logic [1:0] CASE_BEFORE = 2'd1;
    localparam logic [1:0] CASE_AFTER  = 2'd2;
    localparam logic [1:0] CASE_INTERP = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_NWAIT,
        ST_WPREP,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/rtis_ram.sv =====
module rtis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ring_time_interp_search.sv =====
// Ring of timestamps with a nearest-entry search and interpolation weights.
//
// Input channel (i_valid / o_ready): an item is either a write (req_type 0),
// storing entry_time into slot entry_index and optionally marking that slot
// as newest, or a query (req_type 1) for query_time. Writes give no result;
// a write to a slot not below DEPTH is dropped, newest mark included.
// Output channel (o_valid / i_ready): one result item per query, holding two
// bracketing slots, their Q(WEIGHT_FRAC) weights and a case code.
// Throughput: a write leaves the block idle and ready for the next item. A
// query holds the input off until its result is in the output register;
// the input is ready again in the same cycle as that result is offered. The
// single read port of the timestamp RAM is stepped once per slot, then the
// weight comes from a restoring divider giving one quotient bit per cycle.
// Reset: the newest slot becomes DEPTH - 1 and a clearing pass writes zero to
// every slot, one per cycle; o_ready stays low meanwhile.
// Stall: a finished result sits in the output register until taken; the
// block goes on taking writes and can start the next query, but it will not
// overwrite a result that is still waiting.
module ring_time_interp_search
    import rtis_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH,
    parameter int WEIGHT_FRAC = DEF_WEIGHT_FRAC
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [5:0]  i_entry_index,
    input  logic [31:0] i_entry_time,
    input  logic        i_marks_newest,
    input  logic [31:0] i_query_time,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_first_index,
    output logic [5:0]  o_second_index,
    output logic [16:0] o_first_weight,
    output logic [16:0] o_second_weight,
    output logic [1:0]  o_case_code
);

    localparam int AW = $clog2(DEPTH);
    localparam int TW = TIME_WIDTH;
    localparam int WF = WEIGHT_FRAC;
    localparam int WW = WEIGHT_FRAC + 1;
    localparam int CW = $clog2(WEIGHT_FRAC);

    localparam logic [AW-1:0] LAST     = AW'(DEPTH - 1);
    localparam logic [WW-1:0] W_ONE    = WW'(1) << WF;
    localparam logic [CW-1:0] DIV_LAST = CW'(WF - 1);

    t_state r_state, n_state;

    // RAM port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [TW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [TW-1:0] mem_rdata;

    // request decode
    logic [TW+31:0] entry_time_ext;
    logic [TW+31:0] query_time_ext;
    logic [TW-1:0]  entry_time_m;
    logic [AW+5:0]  entry_slot_ext;
    logic [AW-1:0]  entry_slot;
    logic           slot_ok;
    logic           acc_write;
    logic           acc_query;

    // ring pointers
    logic [AW-1:0] r_newest;
    logic [AW-1:0] oldest;
    logic [AW-1:0] r_addr;

    // scan pipeline: read stage, distance stage, compare stage
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic          r_d_vld;
    logic [AW-1:0] r_d_idx;
    logic [TW-1:0] r_d;
    logic          r_d_old;
    logic          r_d_new;
    logic [TW-1:0] r_d_time;

    logic [TW-1:0] r_q;
    logic [TW-1:0] r_best;
    logic [AW-1:0] r_n;
    logic [TW-1:0] r_t_n;
    logic [TW-1:0] r_t_old;
    logic [TW-1:0] r_t_new;

    // decision and weight
    logic          below;
    logic [AW-1:0] nbr;
    logic          r_below;
    logic [AW-1:0] r_i1;
    logic [AW-1:0] r_i2;
    logic [1:0]    r_code;
    logic [WW-1:0] r_w1;
    logic          dec_edge;

    logic [TW-1:0] t1;
    logic [TW-1:0] t2;
    logic [TW-1:0] r_num;
    logic [TW-1:0] r_den;
    logic          r_num_neg;
    logic          r_den_neg;
    logic          wp_special;
    logic [TW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic [TW:0]   rem2;
    logic          div_ge;
    logic [TW:0]   rem_sub;

    // output register
    logic          r_o_valid;
    logic [AW-1:0] r_o_i1;
    logic [AW-1:0] r_o_i2;
    logic [WW-1:0] r_o_w1;
    logic [WW-1:0] r_o_w2;
    logic [1:0]    r_o_code;
    logic          out_free;
    logic [AW+5:0] o_i1_ext;
    logic [AW+5:0] o_i2_ext;
    logic [WW+16:0] o_w1_ext;
    logic [WW+16:0] o_w2_ext;

    rtis_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ---- request decode: fields fitted to the configured widths ----
    assign entry_time_ext = {{TW{1'b0}}, i_entry_time};
    assign query_time_ext = {{TW{1'b0}}, i_query_time};
    assign entry_time_m   = entry_time_ext[TW-1:0];
    assign entry_slot_ext = {{AW{1'b0}}, i_entry_index};
    assign entry_slot     = entry_slot_ext[AW-1:0];
    assign slot_ok        = {7'b0, i_entry_index} < 13'(DEPTH);
    assign acc_write      = (r_state == ST_IDLE) && i_valid && !i_req_type;
    assign acc_query      = (r_state == ST_IDLE) && i_valid && i_req_type;

    // oldest entry sits just after the newest, with wrap-around
    assign oldest = (r_newest == LAST) ? '0 : r_newest + AW'(1);

    // ---- decision terms ----
    assign below    = r_t_n < r_q;
    assign dec_edge = (r_best == '0) || (r_q < r_t_old) || (r_q > r_t_new);
    always_comb begin
        if (below) begin
            nbr = (r_n == LAST) ? '0 : r_n + AW'(1);
        end else begin
            nbr = (r_n == '0) ? LAST : r_n - AW'(1);
        end
    end

    // neighbour arrives from the RAM in ST_NWAIT
    assign t1 = r_below ? r_t_n : mem_rdata;
    assign t2 = r_below ? mem_rdata : r_t_n;

    assign wp_special = (r_den == '0) || (r_num == '0) || (r_num_neg != r_den_neg) ||
                        (r_num >= r_den);

    // restoring divider step: remainder stays below the divisor
    assign rem2    = {r_rem, 1'b0};
    assign div_ge  = rem2 >= {1'b0, r_den};
    assign rem_sub = rem2 - {1'b0, r_den};

    assign out_free = !r_o_valid || i_ready;

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc_query) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_addr == LAST) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_d_vld && (r_d_idx == LAST)) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = dec_edge ? ST_DONE : ST_NWAIT;
            end
            ST_NWAIT: begin
                n_state = ST_WPREP;
            end
            ST_WPREP: begin
                n_state = wp_special ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == DIV_LAST) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // ---- RAM control and handshake ----
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = entry_slot;
        mem_wdata = entry_time_m;
        mem_raddr = r_addr;
        o_ready   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                mem_we  = acc_write && slot_ok;
            end
            ST_DECIDE: begin
                mem_raddr = nbr;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_newest  <= LAST;
            r_rd_vld  <= 1'b0;
            r_d_vld   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN);
            r_d_vld  <= r_rd_vld;

            if ((r_state == ST_CLEAR) || (r_state == ST_SCAN)) begin
                r_addr <= (r_addr == LAST) ? '0 : r_addr + AW'(1);
            end else if (acc_query) begin
                r_addr <= '0;
            end

            if (acc_write && slot_ok && i_marks_newest) begin
                r_newest <= entry_slot;
            end

            if ((r_state == ST_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_q <= query_time_ext[TW-1:0];
        end

        // distance stage
        r_rd_idx <= r_addr;
        if (r_rd_vld) begin
            r_d_idx  <= r_rd_idx;
            r_d      <= (mem_rdata >= r_q) ? mem_rdata - r_q : r_q - mem_rdata;
            r_d_time <= mem_rdata;
            r_d_old  <= (r_rd_idx == oldest);
            r_d_new  <= (r_rd_idx == r_newest);
        end

        // compare stage: strict less keeps the lowest slot on ties
        if (r_d_vld) begin
            if ((r_d_idx == '0) || (r_d < r_best)) begin
                r_best <= r_d;
                r_n    <= r_d_idx;
                r_t_n  <= r_d_time;
            end
            if (r_d_old) r_t_old <= r_d_time;
            if (r_d_new) r_t_new <= r_d_time;
        end

        case (r_state)
            ST_DECIDE: begin
                r_below <= below;
                // interpolation takes the neighbour on the far side of the query
                r_i1    <= (!dec_edge && !below) ? nbr : r_n;
                r_i2    <= (!dec_edge && below) ? nbr : r_n;
                if (r_best == '0) begin
                    r_code <= CASE_EXACT;
                    r_w1   <= W_ONE;
                end else if (r_q < r_t_old) begin
                    r_code <= CASE_BEFORE;
                    r_w1   <= '0;
                end else if (r_q > r_t_new) begin
                    r_code <= CASE_AFTER;
                    r_w1   <= W_ONE;
                end else begin
                    r_code <= CASE_INTERP;
                end
            end
            ST_NWAIT: begin
                r_num     <= (t2 >= r_q) ? t2 - r_q : r_q - t2;
                r_num_neg <= r_q > t2;
                r_den     <= (t2 >= t1) ? t2 - t1 : t1 - t2;
                r_den_neg <= t1 > t2;
            end
            ST_WPREP: begin
                r_rem <= r_num;
                r_cnt <= '0;
                if (r_den == '0) begin
                    r_w1 <= W_ONE;
                end else if ((r_num == '0) || (r_num_neg != r_den_neg)) begin
                    r_w1 <= '0;
                end else if (r_num >= r_den) begin
                    r_w1 <= W_ONE;
                end else begin
                    r_w1 <= '0;
                end
            end
            ST_DIV: begin
                r_rem <= div_ge ? rem_sub[TW-1:0] : rem2[TW-1:0];
                r_w1  <= {1'b0, r_w1[WF-2:0], div_ge};
                r_cnt <= r_cnt + CW'(1);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase

        if ((r_state == ST_DONE) && out_free) begin
            r_o_i1   <= r_i1;
            r_o_i2   <= r_i2;
            r_o_w1   <= r_w1;
            r_o_w2   <= W_ONE - r_w1;
            r_o_code <= r_code;
        end
    end

    // ---- result fields, fitted to the port widths ----
    assign o_i1_ext = {6'b0, r_o_i1};
    assign o_i2_ext = {6'b0, r_o_i2};
    assign o_w1_ext = {17'b0, r_o_w1};
    assign o_w2_ext = {17'b0, r_o_w2};

    assign o_valid         = r_o_valid;
    assign o_first_index   = o_i1_ext[5:0];
    assign o_second_index  = o_i2_ext[5:0];
    assign o_first_weight  = o_w1_ext[16:0];
    assign o_second_weight = o_w2_ext[16:0];
    assign o_case_code     = r_o_code;

endmodule

// ===== hdl/rtis_checker.sv =====
`include "ring_time_interp_search_defines.svh"

module rtis_checker
    import rtis_pkg::*;
#(
    parameter int WEIGHT_FRAC = DEF_WEIGHT_FRAC
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_req_type,
    input logic [5:0]  i_entry_index,
    input logic [31:0] i_entry_time,
    input logic        i_marks_newest,
    input logic [31:0] i_query_time,
    input logic        o_valid,
    input logic        i_ready,
    input logic [5:0]  o_first_index,
    input logic [5:0]  o_second_index,
    input logic [16:0] o_first_weight,
    input logic [16:0] o_second_weight,
    input logic [1:0]  o_case_code
);

    localparam logic [64:0] ONE_WIDE = 65'(1) << WEIGHT_FRAC;
    localparam logic [16:0] ONE17    = ONE_WIDE[16:0];

    logic [16:0] w_sum;

    assign w_sum = o_first_weight + o_second_weight;

    // clearing pass follows reset: nothing offered, nothing taken
    `RTIS_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_valid && !o_ready,
        "result or ready right after reset")

    `RTIS_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_first_index) && $stable(o_second_index) && $stable(o_first_weight) && $stable(o_second_weight) && $stable(o_case_code),
        "stalled result item changed")

    `RTIS_ASSERT(a_weight_sum, o_valid |-> w_sum == ONE17,
        "weights do not add up to one")

    `RTIS_ASSERT(a_edge_same_slot, o_valid && (o_case_code != CASE_INTERP) |-> o_first_index == o_second_index,
        "non-interpolated result names two slots")

    `RTIS_ASSERT(a_before_weight, o_valid && (o_case_code == CASE_BEFORE) |-> o_first_weight == 17'd0,
        "query before oldest entry carries first weight")

endmodule

bind ring_time_interp_search rtis_checker #(
    .WEIGHT_FRAC (WEIGHT_FRAC)
) u_rtis_checker (.*);

// ===== tb/rtis_tb_pkg.sv =====
`timescale 1ns / 1ps

package rtis_tb_pkg;

    // request kinds on the input channel
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

endpackage

// ===== tb/rtis_bracket_checker.sv =====
`timescale 1ns / 1ps

module rtis_bracket_checker
    import rtis_pkg::*;
    import rtis_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel, watched
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_req_type,
    input  logic [5:0]  i_entry_index,
    input  logic [31:0] i_entry_time,
    input  logic        i_marks_newest,
    input  logic [31:0] i_query_time,
    // result channel, watched
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [5:0]  i_first_index,
    input  logic [5:0]  i_second_index,
    input  logic [16:0] i_first_weight,
    input  logic [16:0] i_second_weight,
    input  logic [1:0]  i_case_code,
    output int          o_fail_count,
    output int          o_pending_count
);

    localparam logic [16:0] W_ONE = 17'h1_0000;

    typedef struct packed {
        logic [5:0]  first_index;
        logic [5:0]  second_index;
        logic [16:0] first_weight;
        logic [16:0] second_weight;
        logic [1:0]  case_code;
    } t_bracket;

    // own copy of the ring
    logic [31:0] ring_times [64];
    logic [5:0]  newest;

    t_bracket pending_brackets [$];
    t_bracket got;
    t_bracket want;

    function automatic logic [31:0] time_gap(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // (t2 - q) / (t2 - t1), floored to Q16, clamped to [0, 1]
    function automatic logic [16:0] interp_weight(input logic [31:0] t1, input logic [31:0] t2,
                                                  input logic [31:0] qt);
        logic [31:0] num;
        logic [31:0] den;
        logic [47:0] scaled;
        num = time_gap(t2, qt);
        den = time_gap(t2, t1);
        if (den == 32'd0)
            return W_ONE;
        if (num == 32'd0 || ((qt > t2) != (t1 > t2)))
            return 17'd0;
        if (num >= den)
            return W_ONE;
        scaled = {num, 16'h0000} / {16'h0000, den};
        return scaled[16:0];
    endfunction

    function automatic t_bracket predict_bracket(input logic [31:0] qt);
        t_bracket    res;
        logic [31:0] best_gap;
        logic [5:0]  near;
        logic [5:0]  oldest;
        near     = 6'd0;
        best_gap = time_gap(ring_times[0], qt);
        for (int k = 1; k < 64; k++) begin
            if (time_gap(ring_times[k], qt) < best_gap) begin
                best_gap = time_gap(ring_times[k], qt);
                near     = 6'(k);
            end
        end
        oldest           = newest + 6'd1;
        res.first_index  = near;
        res.second_index = near;
        if (best_gap == 32'd0) begin
            res.case_code    = CASE_EXACT;
            res.first_weight = W_ONE;
        end else if (qt < ring_times[oldest]) begin
            res.case_code    = CASE_BEFORE;
            res.first_weight = 17'd0;
        end else if (qt > ring_times[newest]) begin
            res.case_code    = CASE_AFTER;
            res.first_weight = W_ONE;
        end else begin
            res.case_code = CASE_INTERP;
            // neighbour wraps round the ring
            if (ring_times[near] < qt)
                res.second_index = near + 6'd1;
            else
                res.first_index = near - 6'd1;
            res.first_weight = interp_weight(ring_times[res.first_index],
                                             ring_times[res.second_index], qt);
        end
        res.second_weight = W_ONE - res.first_weight;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got_v, want_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 64; k++)
                ring_times[k] = 32'd0;
            newest = 6'd63;
            pending_brackets.delete();
            o_pending_count <= 0;
        end else begin
            // results first: a query taken this edge cannot already be answered
            if (i_res_valid && i_res_ready) begin
                got = '{i_first_index, i_second_index, i_first_weight, i_second_weight,
                        i_case_code};
                if (pending_brackets.size() == 0) begin
                    report_mismatch("unexpected result", 32'(got.case_code), 32'd0);
                end else begin
                    want = pending_brackets.pop_front();
                    if (got.first_index !== want.first_index)
                        report_mismatch("first_index", 32'(got.first_index),
                                        32'(want.first_index));
                    if (got.second_index !== want.second_index)
                        report_mismatch("second_index", 32'(got.second_index),
                                        32'(want.second_index));
                    if (got.first_weight !== want.first_weight)
                        report_mismatch("first_weight", 32'(got.first_weight),
                                        32'(want.first_weight));
                    if (got.second_weight !== want.second_weight)
                        report_mismatch("second_weight", 32'(got.second_weight),
                                        32'(want.second_weight));
                    if (got.case_code !== want.case_code)
                        report_mismatch("case_code", 32'(got.case_code), 32'(want.case_code));
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_type == REQ_QUERY) begin
                    pending_brackets.push_back(predict_bracket(i_query_time));
                end else begin
                    ring_times[i_entry_index] = i_entry_time;
                    if (i_marks_newest)
                        newest = i_entry_index;
                end
            end
            o_pending_count <= pending_brackets.size();
        end
    end

endmodule

// ===== tb/tb_ring_time_interp_search.sv =====
`timescale 1ns / 1ps

module tb_ring_time_interp_search
    import rtis_tb_pkg::*;
();

    localparam int ITEM_TARGET = 770;   // directed part plus ~750 random
    localparam int CALM_FROM   = 680;   // no idling on either side from here
    localparam int REPICK_STEP = 60;    // items between changes of idling rate
    localparam int QUIET_LIMIT = 3000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES = 200;   // > query latency plus a full stall

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_req_type     = REQ_WRITE;
    logic [5:0]  i_entry_index  = 6'd0;
    logic [31:0] i_entry_time   = 32'd0;
    logic        i_marks_newest = 1'b0;
    logic [31:0] i_query_time   = 32'd0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_first_index;
    logic [5:0]  o_second_index;
    logic [16:0] o_first_weight;
    logic [16:0] o_second_weight;
    logic [1:0]  o_case_code;

    int fail_count;
    int pending_count;

    // idling rates in percent; zero gives stretches with no idling
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    // stimulus-side view of the ring, used to aim queries and to extend the ring
    logic [31:0] shadow_times [64];
    logic [5:0]  shadow_newest = 6'd63;

    ring_time_interp_search dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_time    (i_entry_time),
        .i_marks_newest  (i_marks_newest),
        .i_query_time    (i_query_time),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_first_index   (o_first_index),
        .o_second_index  (o_second_index),
        .o_first_weight  (o_first_weight),
        .o_second_weight (o_second_weight),
        .o_case_code     (o_case_code)
    );

    rtis_bracket_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_time    (i_entry_time),
        .i_marks_newest  (i_marks_newest),
        .i_query_time    (i_query_time),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_first_index   (o_first_index),
        .i_second_index  (o_second_index),
        .i_first_weight  (o_first_weight),
        .i_second_weight (o_second_weight),
        .i_case_code     (o_case_code),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: ready drops in bursts. Bursts land at any point of a
    // query's scan or divide, since they are drawn per cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 10);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: any handshake clears it. Covers the clearing pass after reset
    // and a query's full latency many times over.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        do
            @(posedge i_clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // spacing of consecutive stamps: mostly small, some repeats (zero
    // divisor), some large jumps
    function automatic logic [31:0] next_step();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    // Query time aimed at the current ring: exact hits, between two
    // neighbours, below the oldest, above the newest, or anywhere.
    function automatic logic [31:0] pick_query_time();
        logic [5:0]  slot;
        logic [5:0]  nxt;
        logic [5:0]  oldest;
        logic [31:0] lo;
        logic [31:0] hi;
        slot   = 6'($urandom_range(0, 63));
        nxt    = slot + 6'd1;
        oldest = shadow_newest + 6'd1;
        lo     = shadow_times[slot];
        hi     = shadow_times[nxt];
        case ($urandom_range(0, 9))
            0, 1: return lo;
            2, 3, 4, 5: return (hi >= lo) ? lo + $urandom_range(0, hi - lo) : $urandom;
            6: begin
                lo = shadow_times[oldest];
                return (lo != 32'd0) ? $urandom_range(0, lo - 32'd1) : 32'd0;
            end
            7: begin
                hi = shadow_times[shadow_newest];
                return (hi != 32'hFFFF_FFFF) ? $urandom_range(hi + 32'd1, 32'hFFFF_FFFF) : hi;
            end
            default: return $urandom;
        endcase
    endfunction

    // One item, after an optional gap; returns at the edge that accepts it.
    // Valid is driven once per edge only, so back-to-back items never see a
    // low and a high in the same step.
    task automatic push_item(input t_req req, input logic [5:0] slot, input logic [31:0] stamp,
                             input logic mark, input logic [31:0] qt);
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_entry_index  <= slot;
        i_entry_time   <= stamp;
        i_marks_newest <= mark;
        i_query_time   <= qt;
        do
            @(posedge i_clk);
        while (!o_ready);
        items_sent++;
    endtask

    // unused fields of each kind carry random values
    task automatic put_write(input logic [5:0] slot, input logic [31:0] stamp, input logic mark);
        shadow_times[slot] = stamp;
        if (mark)
            shadow_newest = slot;
        push_item(REQ_WRITE, slot, stamp, mark, $urandom);
    endtask

    task automatic put_query(input logic [31:0] qt);
        push_item(REQ_QUERY, 6'($urandom_range(0, 63)), $urandom, 1'($urandom_range(0, 1)),
                  qt);
    endtask

    // Well-formed ring: 64 non-decreasing stamps written in ring order, each one
    // taking over as newest, so the oldest ends up just after the newest.
    task automatic fill_ring();
        logic [31:0] stamp;
        logic [5:0]  slot;
        stamp = $urandom_range(0, 32'hBFFF_FFFF);
        slot  = 6'($urandom_range(0, 63));
        repeat (64) begin
            put_write(slot, stamp, 1'b1);
            stamp = stamp + next_step();
            slot  = slot + 6'd1;
        end
    endtask

    initial begin
        int action;
        int next_repick;
        for (int k = 0; k < 64; k++)
            shadow_times[k] = 32'd0;
        next_repick = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Fresh ring is all zero, newest slot 63, oldest 0.
        put_query(32'd0);                   // exact, ties go to slot 0
        put_query(32'hFFFF_FFFF);           // after newest on an empty ring
        put_write(6'd0, 32'd100, 1'b0);
        put_query(32'd50);                  // below the oldest entry
        put_write(6'd63, 32'd1000, 1'b1);
        put_write(6'd62, 32'd900, 1'b0);
        put_query(32'd950);                 // halfway between 62 and 63
        put_query(32'd1000);                // exact on the newest
        put_query(32'd2000);                // beyond the newest
        put_query(32'd120);                 // neighbour 1 holds zero: weight clamps to one
        put_write(6'd5, 32'd5000, 1'b1);    // newest moves to 5, oldest 6
        put_write(6'd0, 32'd300, 1'b0);
        put_query(32'd290);                 // neighbour wraps back to 63, weight clamps to zero
        put_write(6'd20, 32'd700, 1'b0);
        put_write(6'd21, 32'd700, 1'b0);
        put_query(32'd710);                 // equal neighbours: zero divisor
        put_write(6'd40, 32'hFFFF_FFFF, 1'b0);
        put_query(32'hFFFF_FFFF);           // exact on the top stamp
        put_query(32'hFFFF_FFFE);           // above newest, nearest is the top stamp
        put_write(6'd63, 32'hFFFF_FFFF, 1'b1);
        put_query(32'd0);                   // exact on a zero slot
        put_query(32'd5);                   // below oldest (slot 0 holds 300)

        // Random part: mostly a well-formed ring that keeps advancing, with
        // aimed queries; the rest stray writes that break the ordering.
        fill_ring();
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= CALM_FROM) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (items_sent >= next_repick) begin
                gap_pct     = pick_pct();
                stall_pct   = pick_pct();
                next_repick = items_sent + REPICK_STEP;
            end
            action = $urandom_range(0, 39);
            if (action < 20)
                put_query(pick_query_time());
            else if (action < 32)
                repeat ($urandom_range(1, 6))
                    put_write(shadow_newest + 6'd1, shadow_times[shadow_newest] + next_step(),
                              1'b1);
            else if (action < 38)
                put_write(6'($urandom_range(0, 63)), $urandom, 1'($urandom_range(0, 1)));
            else
                fill_ring();
        end
        i_valid <= 1'b0;

        // drain, then watch a while for anything unasked-for
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rtis_pkg.sv
hdl/rtis_ram.sv
hdl/ring_time_interp_search.sv
hdl/rtis_checker.sv
tb/rtis_tb_pkg.sv
tb/rtis_bracket_checker.sv
tb/tb_ring_time_interp_search.sv
